// ----- rtl/hmn_pkg.sv -----
`default_nettype none
package hmn_pkg;

   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_ROWS    = 4096;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int DIM_W       = 13;
   localparam int H_W         = 16;
   localparam int DIFF_W      = H_W + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int MAG_W       = 15;
   localparam int NRM_W       = 16;
   localparam int STEPS       = 16;
   localparam int STEP_CNT_W  = $clog2(STEPS);
   localparam int NORM_SHIFT  = 2 * (STEPS - 1);
   localparam int NACC_W      = SQ_W + NORM_SHIFT + 2;
   localparam int TWO_Q8_8    = 512;
   localparam int TWO_SQ      = TWO_Q8_8 * TWO_Q8_8;

   localparam logic CSR_MAP_COLUMNS = 1'b0;
   localparam logic CSR_MAP_ROWS    = 1'b1;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_READ   = 9'b000000010,
      S_WRITE  = 9'b000000100,
      S_PICK   = 9'b000001000,
      S_SQ     = 9'b000010000,
      S_SUM    = 9'b000100000,
      S_NSTART = 9'b001000000,
      S_NWAIT  = 9'b010000000,
      S_EMIT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [SQ_W-1:0]   sq;
      logic [SQ_W-1:0]   s;
   } norm_req_type;

   typedef struct packed {
      logic              done;
      logic [MAG_W-1:0]  mag;
   } norm_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/hmn_ram.sv -----
`default_nettype none
module hmn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ----- rtl/hmn_norm.sv -----
`default_nettype none
module hmn_norm (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hmn_pkg::norm_req_type req,
   output hmn_pkg::norm_rsp_type      rsp
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [hmn_pkg::STEP_CNT_W-1:0]    cnt_ff;
   logic [hmn_pkg::NACC_W-1:0]        r_ff;
   logic [hmn_pkg::NACC_W-1:0]        u_ff;
   logic [hmn_pkg::NACC_W-1:0]        w_ff;
   logic [hmn_pkg::STEPS-1:0]         t_ff;
   logic [hmn_pkg::NACC_W-1:0]        d;
   logic                              take;
   logic [hmn_pkg::STEPS:0]           t_rnd;

   // trial term (T+2^k)^2*s - T^2*s, restoring one result bit per cycle
   assign d    = u_ff + w_ff;
   assign take = r_ff >= d;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == hmn_pkg::STEP_CNT_W'(hmn_pkg::STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         r_ff <= hmn_pkg::NACC_W'(req.sq) << hmn_pkg::NORM_SHIFT;
         u_ff <= '0;
         w_ff <= hmn_pkg::NACC_W'(req.s) << hmn_pkg::NORM_SHIFT;
         t_ff <= '0;
      end else if (busy_ff) begin
         if (take) begin
            r_ff <= r_ff - d;
            u_ff <= (u_ff >> 1) + w_ff;
         end else begin
            u_ff <= u_ff >> 1;
         end
         w_ff <= w_ff >> 2;
         t_ff <= {t_ff[hmn_pkg::STEPS-2:0], take};
      end
   end

   // t holds floor of twice the scaled magnitude, so this rounds half away
   assign t_rnd    = {1'b0, t_ff} + 1'b1;
   assign rsp.done = done_ff;
   assign rsp.mag  = hmn_pkg::MAG_W'(t_rnd >> 1);

endmodule
`default_nettype wire

// ----- rtl/heightmap_normal_generator.sv -----
// sequence: the first normal of a sample follows its transfer through the row store reads,
//    write-back, pick, square, sum, 3 passes of the shared bit-serial normalizer and
//    emit; each further normal of the same sample repeats pick through emit
// samples: one at a time; each releases 0 to 3 normals before the next sample is
//    taken; a result held by rsp_ready stalls the next emit
// reset: counters clear, dimensions return to 256 x 256; row stores are not cleared
`default_nettype none
module heightmap_normal_generator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_height_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_normal_x,
   output logic        [14:0]      rsp_normal_y,
   output logic signed [15:0]      rsp_normal_z,
   output logic [hmn_pkg::COL_W-1:0] rsp_out_column,
   output logic [hmn_pkg::ROW_W-1:0] rsp_out_row,
   output logic                    rsp_last_of_step,
   output logic                    rsp_frame_done,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [12:0]        csr_data
);

   localparam int CW = hmn_pkg::COL_W;
   localparam int RW = hmn_pkg::ROW_W;
   localparam int HW = hmn_pkg::H_W;
   localparam int DW = hmn_pkg::DIFF_W;
   localparam int QW = hmn_pkg::SQ_W;

   hmn_pkg::state_type state_ff;

   logic [CW:0]   cols_ff;
   logic [RW:0]   rows_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [CW-1:0] lc;
   logic [RW-1:0] lr;
   logic          row_end;
   logic          last_row;

   logic [CW-1:0]        x_ff;
   logic [RW-1:0]        z_ff;
   logic signed [HW-1:0] cur_ff;
   logic [2:0]           pend_ff;
   logic [2:0]           rd_cnt_ff;
   logic signed [HW-1:0] hm_ff [4];
   logic signed [HW-1:0] hu_ff [2];

   logic signed [DW-1:0] a_ff, b_ff;
   logic [QW-1:0]        asq_ff, bsq_ff, s_ff;
   logic [1:0]           comp_ff;
   logic [2:0]           sel_ff;
   logic [CW-1:0]        ncol_ff;
   logic [RW-1:0]        nrow_ff;
   logic [hmn_pkg::MAG_W-1:0] my_ff;
   logic signed [15:0]   nx_ff, nz_ff;
   logic                 start_ff;

   logic                 rsp_valid_ff;
   logic signed [15:0]   rsp_x_ff, rsp_z_ff;
   logic [14:0]          rsp_y_ff;
   logic [CW-1:0]        rsp_col_ff;
   logic [RW-1:0]        rsp_row_ff;
   logic                 rsp_last_ff, rsp_done_ff;

   logic                 req_fire, csr_fire;
   logic [CW-1:0]        xm1, xm2, rcol1;
   logic [CW:0]          xp1;
   logic                 x_ge1, z0, z1, z_gt_lr, x_le_lc;
   logic [CW-1:0]        mid_raddr, up_raddr;
   logic [HW-1:0]        mid_rdata, up_rdata;
   logic                 mem_we;
   logic [2:0]           sel;
   logic signed [DW-1:0] a_in, b_in;
   logic [CW-1:0]        ncol_in;
   logic [RW-1:0]        nrow_in;
   logic [QW-1:0]        asq_in, bsq_in;
   logic signed [2*DW-1:0] asq_full, bsq_full;
   hmn_pkg::norm_req_type nreq;
   hmn_pkg::norm_rsp_type nrsp;
   logic                 neg;
   logic [15:0]          mag16;
   logic [15:0]          signed_mag;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   // a register write takes the idle cycle ahead of a sample
   assign req_ready = (state_ff == hmn_pkg::S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == hmn_pkg::S_IDLE);

   assign lc       = CW'(cols_ff - 1'b1);
   assign lr       = RW'(rows_ff - 1'b1);
   assign row_end  = col_ff >= lc;
   assign last_row = row_ff >= lr;

   // dimensions, saturated into 1..max
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= (CW + 1)'(256);
         rows_ff <= (RW + 1)'(256);
      end else if (csr_fire) begin
         unique case (csr_index)
            hmn_pkg::CSR_MAP_COLUMNS: begin
               if (csr_data == '0) begin
                  cols_ff <= (CW + 1)'(1);
               end else if (32'(csr_data) > hmn_pkg::MAX_COLUMNS) begin
                  cols_ff <= (CW + 1)'(hmn_pkg::MAX_COLUMNS);
               end else begin
                  cols_ff <= (CW + 1)'(csr_data);
               end
            end
            hmn_pkg::CSR_MAP_ROWS: begin
               if (csr_data == '0) begin
                  rows_ff <= (RW + 1)'(1);
               end else if (32'(csr_data) > hmn_pkg::MAX_ROWS) begin
                  rows_ff <= (RW + 1)'(hmn_pkg::MAX_ROWS);
               end else begin
                  rows_ff <= (RW + 1)'(csr_data);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // neighbour addresses for the item in flight
   assign x_ge1   = x_ff != '0;
   assign z0      = z_ff == '0;
   assign z1      = z_ff == RW'(1);
   assign z_gt_lr = z_ff > lr;
   assign x_le_lc = x_ff <= lc;
   assign xm1     = x_ge1 ? x_ff - 1'b1 : '0;
   assign xm2     = (x_ff >= CW'(2)) ? x_ff - CW'(2) : '0;
   assign xp1     = {1'b0, x_ff} + 1'b1;
   always_comb begin
      rcol1 = (xp1 > {1'b0, lc}) ? lc : CW'(xp1);
      if (rcol1 < x_ff) begin
         rcol1 = x_ff;
      end
   end

   always_comb begin
      mid_raddr = x_ff;
      up_raddr  = x_ff;
      unique case (rd_cnt_ff)
         3'd0: begin
            mid_raddr = x_ff;
            up_raddr  = xm1;
         end
         3'd1: mid_raddr = rcol1;
         3'd2: mid_raddr = xm1;
         3'd3: mid_raddr = xm2;
         default: begin
         end
      endcase
   end

   assign mem_we = (state_ff == hmn_pkg::S_WRITE);

   hmn_ram #(.WIDTH(HW), .DEPTH(hmn_pkg::MAX_COLUMNS)) u_upper (
      .clock (clock),
      .we    (mem_we),
      .waddr (x_ff),
      .wdata (hm_ff[0]),
      .raddr (up_raddr),
      .rdata (up_rdata)
   );

   hmn_ram #(.WIDTH(HW), .DEPTH(hmn_pkg::MAX_COLUMNS)) u_middle (
      .clock (clock),
      .we    (mem_we),
      .waddr (x_ff),
      .wdata (cur_ff),
      .raddr (mid_raddr),
      .rdata (mid_rdata)
   );

   // pick the earliest pending normal and form its difference vector
   always_comb begin
      sel = 3'b000;
      priority if (pend_ff[0]) begin
         sel = 3'b001;
      end else if (pend_ff[1]) begin
         sel = 3'b010;
      end else if (pend_ff[2]) begin
         sel = 3'b100;
      end else begin
         sel = 3'b000;
      end
   end

   always_comb begin
      a_in    = '0;
      b_in    = '0;
      ncol_in = x_ff;
      nrow_in = z_ff;
      priority if (sel[0]) begin
         a_in    = DW'(z1 ? hm_ff[0] : hu_ff[1]) - DW'(z_gt_lr ? hm_ff[0] : cur_ff);
         b_in    = DW'(hm_ff[1]) - DW'(x_ge1 ? hu_ff[0] : hm_ff[0]);
         nrow_in = z_ff - 1'b1;
      end else if (sel[1]) begin
         a_in    = DW'(z0 ? hm_ff[2] : hu_ff[0]) - DW'(hm_ff[2]);
         b_in    = DW'(x_le_lc ? cur_ff : hm_ff[2]) - DW'(hm_ff[3]);
         ncol_in = x_ff - 1'b1;
      end else if (sel[2]) begin
         a_in    = DW'(z0 ? cur_ff : hm_ff[0]) - DW'(cur_ff);
         b_in    = DW'(cur_ff) - DW'(x_ge1 ? hm_ff[2] : cur_ff);
      end else begin
         a_in    = '0;
      end
   end

   assign asq_full = a_ff * a_ff;
   assign bsq_full = b_ff * b_ff;
   assign asq_in   = QW'(asq_full);
   assign bsq_in   = QW'(bsq_full);

   always_comb begin
      nreq.start = start_ff;
      nreq.s     = s_ff;
      unique case (comp_ff)
         2'd0:    nreq.sq = asq_ff;
         2'd1:    nreq.sq = QW'(hmn_pkg::TWO_SQ);
         default: nreq.sq = bsq_ff;
      endcase
   end

   hmn_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (nreq),
      .rsp   (nrsp)
   );

   assign neg        = (comp_ff == 2'd0) ? a_ff[DW-1] : b_ff[DW-1];
   assign mag16      = {1'b0, nrsp.mag};
   assign signed_mag = neg ? 16'(-mag16) : mag16;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hmn_pkg::S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rd_cnt_ff    <= '0;
         pend_ff      <= '0;
         comp_ff      <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            hmn_pkg::S_IDLE: begin
               if (req_fire) begin
                  pend_ff   <= {last_row && row_end, last_row && (col_ff != '0),
                                row_ff != '0};
                  rd_cnt_ff <= '0;
                  state_ff  <= hmn_pkg::S_READ;
                  if (row_end) begin
                     col_ff <= '0;
                     row_ff <= last_row ? '0 : row_ff + 1'b1;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            hmn_pkg::S_READ: begin
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
               if (rd_cnt_ff == 3'd4) begin
                  state_ff <= hmn_pkg::S_WRITE;
               end
            end
            hmn_pkg::S_WRITE: state_ff <= hmn_pkg::S_PICK;
            hmn_pkg::S_PICK: begin
               state_ff <= (pend_ff == '0) ? hmn_pkg::S_IDLE : hmn_pkg::S_SQ;
            end
            hmn_pkg::S_SQ: state_ff <= hmn_pkg::S_SUM;
            hmn_pkg::S_SUM: begin
               comp_ff  <= '0;
               state_ff <= hmn_pkg::S_NSTART;
            end
            hmn_pkg::S_NSTART: begin
               start_ff <= 1'b1;
               state_ff <= hmn_pkg::S_NWAIT;
            end
            hmn_pkg::S_NWAIT: begin
               if (nrsp.done) begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= (comp_ff == 2'd2) ? hmn_pkg::S_EMIT : hmn_pkg::S_NSTART;
               end
            end
            hmn_pkg::S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  pend_ff      <= pend_ff & ~sel_ff;
                  state_ff     <= hmn_pkg::S_PICK;
               end
            end
            default: state_ff <= hmn_pkg::S_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff   <= col_ff;
         z_ff   <= row_ff;
         cur_ff <= req_height_sample;
      end
      if (state_ff == hmn_pkg::S_READ && rd_cnt_ff != 3'd0) begin
         hm_ff[2'(rd_cnt_ff - 1'b1)] <= mid_rdata;
         if (rd_cnt_ff <= 3'd2) begin
            hu_ff[1'(rd_cnt_ff - 1'b1)] <= up_rdata;
         end
      end
      if (state_ff == hmn_pkg::S_PICK) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         sel_ff  <= sel;
         ncol_ff <= ncol_in;
         nrow_ff <= nrow_in;
      end
      if (state_ff == hmn_pkg::S_SQ) begin
         asq_ff <= asq_in;
         bsq_ff <= bsq_in;
      end
      if (state_ff == hmn_pkg::S_SUM) begin
         s_ff <= asq_ff + bsq_ff + QW'(hmn_pkg::TWO_SQ);
      end
      if (state_ff == hmn_pkg::S_NWAIT && nrsp.done) begin
         unique case (comp_ff)
            2'd0:    nx_ff <= signed_mag;
            2'd1:    my_ff <= nrsp.mag;
            default: nz_ff <= signed_mag;
         endcase
      end
      if (state_ff == hmn_pkg::S_EMIT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_x_ff    <= nx_ff;
         rsp_y_ff    <= my_ff;
         rsp_z_ff    <= nz_ff;
         rsp_col_ff  <= ncol_ff;
         rsp_row_ff  <= nrow_ff;
         rsp_last_ff <= (pend_ff & ~sel_ff) == '0;
         rsp_done_ff <= sel_ff[2];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_normal_x     = rsp_x_ff;
   assign rsp_normal_y     = rsp_y_ff;
   assign rsp_normal_z     = rsp_z_ff;
   assign rsp_out_column   = rsp_col_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_last_of_step = rsp_last_ff;
   assign rsp_frame_done   = rsp_done_ff;

endmodule
`default_nettype wire
